// ===== hw/rtl/phad_pkg.sv =====
// ----------------------------------------------------------------------------
// Process health anomaly detector package
// Window sizes, field widths, register indexes and reset values shared by
// the interfaces and the modules of the detector.
// ----------------------------------------------------------------------------
package phad_pkg;

  localparam int MEM_WINDOW = 20;
  localparam int CPU_WINDOW = 10;
  localparam int FD_WINDOW  = 60;

  localparam int MEM_DEPTH = MEM_WINDOW - 1;
  localparam int FD_DEPTH  = FD_WINDOW - 1;
  localparam int SEEN_CAP  = (MEM_WINDOW > CPU_WINDOW) ?
                             ((MEM_WINDOW > FD_WINDOW) ? MEM_WINDOW : FD_WINDOW) :
                             ((CPU_WINDOW > FD_WINDOW) ? CPU_WINDOW : FD_WINDOW);

  localparam int SEEN_W = $clog2(SEEN_CAP + 1);
  localparam int RISE_W = $clog2(MEM_DEPTH + 1);
  localparam int HIGH_W = $clog2(CPU_WINDOW + 1);

  localparam int RESIDENT_W   = 32;
  localparam int CPU_W        = 16;
  localparam int DESC_W       = 20;
  localparam int CLOSE_WAIT_W = 16;

  localparam int MEM_LIMIT_W = 20;
  localparam int CPU_LIMIT_W = 16;
  localparam int FD_LIMIT_W  = 16;
  localparam int CW_LIMIT_W  = 16;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 20;

  localparam logic [MEM_LIMIT_W-1:0] MEM_LIMIT_RESET = MEM_LIMIT_W'(5120);
  localparam logic [CPU_LIMIT_W-1:0] CPU_LIMIT_RESET = CPU_LIMIT_W'(900);
  localparam logic [FD_LIMIT_W-1:0]  FD_LIMIT_RESET  = FD_LIMIT_W'(50);
  localparam logic [CW_LIMIT_W-1:0]  CW_LIMIT_RESET  = CW_LIMIT_W'(10);

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_MEM_GROWTH_LIMIT = 2'd0,
    REG_CPU_LIMIT        = 2'd1,
    REG_FD_GROWTH_LIMIT  = 2'd2,
    REG_CLOSE_WAIT_LIMIT = 2'd3
  } cfg_reg_t;

endpackage

// ===== hw/rtl/phad_interfaces.sv =====
// ----------------------------------------------------------------------------
// Process health anomaly detector channels
// Snapshot, findings and configuration write channels with valid/ready.
// ----------------------------------------------------------------------------
interface phad_snapshot_if import phad_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    alive;
  logic [RESIDENT_W-1:0]   resident_kb;
  logic [CPU_W-1:0]        cpu_tenths;
  logic [DESC_W-1:0]       open_descriptors;
  logic [CLOSE_WAIT_W-1:0] close_wait_sockets;

  modport source (output valid, alive, resident_kb, cpu_tenths, open_descriptors,
                  close_wait_sockets, input ready);
  modport sink (input valid, alive, resident_kb, cpu_tenths, open_descriptors,
                close_wait_sockets, output ready);
endinterface

interface phad_findings_if;
  logic valid;
  logic ready;
  logic crash_found;
  logic memory_leak_found;
  logic cpu_spike_found;
  logic descriptor_leak_found;
  logic socket_leak_found;

  modport source (output valid, crash_found, memory_leak_found, cpu_spike_found,
                  descriptor_leak_found, socket_leak_found, input ready);
  modport sink (input valid, crash_found, memory_leak_found, cpu_spike_found,
                descriptor_leak_found, socket_leak_found, output ready);
endinterface

interface phad_cfg_if import phad_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/phad_mem_cell.sv =====
// ----------------------------------------------------------------------------
// Memory history cell
// One stage of the resident memory delay line; takes its neighbour's word
// on every accepted snapshot.
// ----------------------------------------------------------------------------
module phad_mem_cell import phad_pkg::*; (
  input  logic                  clk,
  input  logic                  shift,
  input  logic [RESIDENT_W-1:0] d,
  output logic [RESIDENT_W-1:0] q
);

  always_ff @(posedge clk) begin
    if (shift) begin
      q <= d;
    end
  end

endmodule

// ===== hw/rtl/phad_fd_cell.sv =====
// ----------------------------------------------------------------------------
// Descriptor history cell
// One stage of the open descriptor delay line; takes its neighbour's count
// on every accepted snapshot.
// ----------------------------------------------------------------------------
module phad_fd_cell import phad_pkg::*; (
  input  logic              clk,
  input  logic              shift,
  input  logic [DESC_W-1:0] d,
  output logic [DESC_W-1:0] q
);

  always_ff @(posedge clk) begin
    if (shift) begin
      q <= d;
    end
  end

endmodule

// ===== hw/rtl/process_health_anomaly_detector_unit.sv =====
// ----------------------------------------------------------------------------
// Process health anomaly detector
// Judges one process health snapshot per transaction and returns five
// finding flags.
// ----------------------------------------------------------------------------
// A snapshot is taken in every cycle in which the findings register is empty
// or being drained, so the block sustains one transaction per clock; the
// findings of a snapshot show in the cycle after it is taken. The history of
// resident sizes and descriptor counts lives in two chains of delay cells
// that advance once per snapshot, and the run counters update in the same
// cycle. No finding is raised before the second snapshot after reset.
module process_health_anomaly_detector_unit import phad_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  phad_snapshot_if.sink   snapshot,
  phad_findings_if.source findings,
  phad_cfg_if.sink        cfg
);

  logic [MEM_LIMIT_W-1:0] mem_limit;
  logic [CPU_LIMIT_W-1:0] cpu_limit;
  logic [FD_LIMIT_W-1:0]  fd_limit;
  logic [CW_LIMIT_W-1:0]  cw_limit;

  logic [SEEN_W-1:0] samples_seen;
  logic [SEEN_W-1:0] samples_seen_next;
  logic              previous_alive;
  logic [RISE_W-1:0] rise_run;
  logic [RISE_W-1:0] rise_run_next;
  logic [HIGH_W-1:0] high_run;
  logic [HIGH_W-1:0] high_run_next;

  logic [RESIDENT_W-1:0] mem_tap [MEM_DEPTH+1];
  logic [DESC_W-1:0]     fd_tap [FD_DEPTH+1];

  logic                take;
  logic [RESIDENT_W:0] mem_bound;
  logic [DESC_W:0]     fd_bound;
  logic                crash;
  logic                mleak;
  logic                spike;
  logic                fleak;
  logic                sock;

  assign take = snapshot.valid && snapshot.ready;
  assign snapshot.ready = !findings.valid || findings.ready;
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mem_limit <= MEM_LIMIT_RESET;
      cpu_limit <= CPU_LIMIT_RESET;
      fd_limit  <= FD_LIMIT_RESET;
      cw_limit  <= CW_LIMIT_RESET;
    end else if (cfg.valid) begin
      unique case (cfg_reg_t'(cfg.index))
        REG_MEM_GROWTH_LIMIT: mem_limit <= cfg.data[MEM_LIMIT_W-1:0];
        REG_CPU_LIMIT:        cpu_limit <= cfg.data[CPU_LIMIT_W-1:0];
        REG_FD_GROWTH_LIMIT:  fd_limit  <= cfg.data[FD_LIMIT_W-1:0];
        REG_CLOSE_WAIT_LIMIT: cw_limit  <= cfg.data[CW_LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  assign mem_tap[0] = snapshot.resident_kb;
  assign fd_tap[0]  = snapshot.open_descriptors;

  for (genvar i = 0; i < MEM_DEPTH; i++) begin : g_mem
    phad_mem_cell u_cell (
      .clk   (clk),
      .shift (take),
      .d     (mem_tap[i]),
      .q     (mem_tap[i+1])
    );
  end

  for (genvar i = 0; i < FD_DEPTH; i++) begin : g_fd
    phad_fd_cell u_cell (
      .clk   (clk),
      .shift (take),
      .d     (fd_tap[i]),
      .q     (fd_tap[i+1])
    );
  end

  always_comb begin
    samples_seen_next = (samples_seen < SEEN_W'(SEEN_CAP)) ?
                        samples_seen + SEEN_W'(1) : samples_seen;

    if (samples_seen != '0 && snapshot.resident_kb >= mem_tap[1]) begin
      rise_run_next = (rise_run < RISE_W'(MEM_DEPTH)) ? rise_run + RISE_W'(1) : rise_run;
    end else begin
      rise_run_next = '0;
    end

    if (snapshot.cpu_tenths > cpu_limit) begin
      high_run_next = (high_run < HIGH_W'(CPU_WINDOW)) ? high_run + HIGH_W'(1) : high_run;
    end else begin
      high_run_next = '0;
    end

    mem_bound = {1'b0, mem_tap[MEM_DEPTH]} + (RESIDENT_W+1)'(mem_limit);
    fd_bound  = {1'b0, fd_tap[FD_DEPTH]} + (DESC_W+1)'(fd_limit);

    crash = 1'b0;
    mleak = 1'b0;
    spike = 1'b0;
    fleak = 1'b0;
    sock  = 1'b0;
    if (samples_seen_next >= SEEN_W'(2)) begin
      crash = previous_alive && !snapshot.alive;
      mleak = (samples_seen_next >= SEEN_W'(MEM_WINDOW)) &&
              (rise_run_next >= RISE_W'(MEM_DEPTH)) &&
              ({1'b0, snapshot.resident_kb} > mem_bound);
      spike = (samples_seen_next >= SEEN_W'(CPU_WINDOW)) &&
              (high_run_next >= HIGH_W'(CPU_WINDOW));
      fleak = (samples_seen_next >= SEEN_W'(FD_WINDOW)) &&
              ({1'b0, snapshot.open_descriptors} > fd_bound);
      sock  = snapshot.close_wait_sockets > cw_limit;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      samples_seen   <= '0;
      previous_alive <= 1'b0;
      rise_run       <= '0;
      high_run       <= '0;
      findings.valid <= 1'b0;
    end else begin
      if (take) begin
        samples_seen   <= samples_seen_next;
        previous_alive <= snapshot.alive;
        rise_run       <= rise_run_next;
        high_run       <= high_run_next;
        findings.valid <= 1'b1;
      end else if (findings.ready) begin
        findings.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      findings.crash_found           <= crash;
      findings.memory_leak_found     <= mleak;
      findings.cpu_spike_found       <= spike;
      findings.descriptor_leak_found <= fleak;
      findings.socket_leak_found     <= sock;
    end
  end

endmodule
